// ===== rtl/core/nca_pkg.sv =====
// nca_pkg: types, command codes and constant tables for the nibble calculator alu
// no dependencies; used by every module under rtl/core
package nca_pkg;

	// command codes
	localparam logic [3:0] CMD_ADD   = 4'd0;
	localparam logic [3:0] CMD_SUB   = 4'd1;
	localparam logic [3:0] CMD_MUL   = 4'd2;
	localparam logic [3:0] CMD_DIV   = 4'd3;
	localparam logic [3:0] CMD_AND   = 4'd4;
	localparam logic [3:0] CMD_OR    = 4'd5;
	localparam logic [3:0] CMD_XOR   = 4'd6;
	localparam logic [3:0] CMD_NAND  = 4'd7;
	localparam logic [3:0] CMD_NOR   = 4'd8;
	localparam logic [3:0] CMD_XNOR  = 4'd9;
	localparam logic [3:0] CMD_ROL1  = 4'd10;
	localparam logic [3:0] CMD_SWAP  = 4'd11;
	localparam logic [3:0] CMD_POW   = 4'd12;
	localparam logic [3:0] CMD_ROOT  = 4'd13;
	localparam logic [3:0] CMD_ROLB  = 4'd14;

	localparam logic [3:0]  NIB_MASK = 4'h0F;
	localparam logic [15:0] SAT_MAX  = 16'hFFFF;

	// request and response payloads
	typedef struct packed {
		logic [3:0] operand_a;
		logic [3:0] operand_b;
		logic [3:0] command;
	} in_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic        is_negative;
		logic        has_error;
	} out_t;

	// result carried down the pipe, plus what the power chain still needs
	typedef struct packed {
		logic [15:0] result_value;
		logic        is_negative;
		logic        has_error;
		logic        is_pow;
		logic [3:0]  expo;
	} side_t;

	// stage 1 output: finished result for all but power, first power step
	typedef struct packed {
		side_t      side;
		logic [7:0] sq;
		logic [3:0] acc;
	} front_t;

	// stage load enables for the power chain
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} power_en_t;

	// saturating power term: over set once the value passed 16 bits
	typedef struct packed {
		logic        over;
		logic [15:0] val;
	} pow_t;

	typedef logic [255:0][11:0] root_tab_t;

	function automatic pow_t pow_mul(pow_t x, pow_t y);
		logic [31:0] prod;
		pow_t        res;
		prod     = 32'(x.val) * 32'(y.val);
		res.over = x.over | y.over | (|prod[31:16]);
		res.val  = prod[15:0];
		return res;
	endfunction

	// restoring divide, 4 quotient bits
	function automatic logic [3:0] nib_div(logic [3:0] num, logic [3:0] den);
		logic [4:0] rem;
		logic [3:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 3; i >= 0; i--) begin
			rem = {rem[3:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// largest r with r^b <= a * 2^(8b), i.e. a^(1/b) in q4.8 truncated
	function automatic root_tab_t build_root_tab();
		root_tab_t    tab;
		logic [191:0] lhs;
		logic [191:0] rhs;
		logic [11:0]  r;
		logic [11:0]  cand;
		tab = '0;
		for (int a = 0; a < 16; a++) begin
			for (int b = 1; b < 16; b++) begin
				r   = '0;
				rhs = 192'(a) << (8 * b);
				for (int k = 11; k >= 0; k--) begin
					cand = r | (12'd1 << k);
					lhs  = 192'd1;
					for (int i = 0; i < b; i++) begin
						lhs = lhs * 192'(cand);
					end
					if (lhs <= rhs) begin
						r = cand;
					end
				end
				tab[8'(a * 16 + b)] = r;
			end
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

// ===== rtl/core/nca_front.sv =====
// nca_front: first pipeline stage, decodes the command and computes every
// result except power; starts the power chain. depends on nca_pkg
module nca_front (
	input  logic            clk,
	input  logic            load,
	input  nca_pkg::in_t    req,
	output nca_pkg::front_t front
);

	nca_pkg::front_t nxt;
	nca_pkg::front_t front_s1;
	logic [7:0]      byte_ab;
	logic [15:0]     rot_word;
	logic [3:0]      a;
	logic [3:0]      b;

	assign a        = req.operand_a;
	assign b        = req.operand_b;
	assign byte_ab  = {a, b};
	// rotate of {0000,a} by b mod 8 taken from the doubled byte
	assign rot_word = {4'b0, a, 4'b0, a} << b[2:0];

	always_comb begin
		nxt                   = '0;
		nxt.side.expo         = b;
		nxt.sq                = {4'b0, a} * {4'b0, a};
		nxt.acc               = b[0] ? a : 4'd1;
		case (req.command)
			nca_pkg::CMD_ADD: nxt.side.result_value = 16'(a) + 16'(b);
			nca_pkg::CMD_SUB: begin
				if (b > a) begin
					nxt.side.result_value = 16'(b - a);
					nxt.side.is_negative  = 1'b1;
				end else begin
					nxt.side.result_value = 16'(a - b);
				end
			end
			nca_pkg::CMD_MUL: nxt.side.result_value = 16'({4'b0, a} * {4'b0, b});
			nca_pkg::CMD_DIV: begin
				if (b == 4'd0 || a < b) begin
					nxt.side.has_error = 1'b1;
				end else begin
					nxt.side.result_value = 16'(nca_pkg::nib_div(a, b));
				end
			end
			nca_pkg::CMD_AND:  nxt.side.result_value = 16'(a & b);
			nca_pkg::CMD_OR:   nxt.side.result_value = 16'(a | b);
			nca_pkg::CMD_XOR:  nxt.side.result_value = 16'(a ^ b);
			nca_pkg::CMD_NAND: nxt.side.result_value = 16'(~(a & b) & nca_pkg::NIB_MASK);
			nca_pkg::CMD_NOR:  nxt.side.result_value = 16'(~(a | b) & nca_pkg::NIB_MASK);
			nca_pkg::CMD_XNOR: nxt.side.result_value = 16'(~(a ^ b) & nca_pkg::NIB_MASK);
			nca_pkg::CMD_ROL1: nxt.side.result_value = 16'({byte_ab[6:0], byte_ab[7]});
			nca_pkg::CMD_SWAP: nxt.side.result_value = 16'({b, a});
			nca_pkg::CMD_POW:  nxt.side.is_pow = 1'b1;
			nca_pkg::CMD_ROOT: begin
				if (b == 4'd0) begin
					nxt.side.has_error = 1'b1;
				end else begin
					nxt.side.result_value = 16'(nca_pkg::ROOT_TAB[byte_ab]);
				end
			end
			nca_pkg::CMD_ROLB: nxt.side.result_value = 16'(rot_word[15:8]);
			default:           nxt.side.has_error = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_s1 <= nxt;
		end
	end

	assign front = front_s1;

endmodule

// ===== rtl/core/nca_power.sv =====
// nca_power: stages 2 to 4, square-and-multiply chain for a^b with 16-bit
// saturation, and the final result select. depends on nca_pkg
module nca_power (
	input  logic                clk,
	input  nca_pkg::power_en_t  en,
	input  nca_pkg::front_t     front,
	output nca_pkg::out_t       rsp
);

	nca_pkg::side_t side_s2;
	nca_pkg::side_t side_s3;
	logic [15:0]    x_s2;      // a^4
	logic [11:0]    acc_s2;    // a^(b mod 4)
	nca_pkg::pow_t  x_s3;      // a^8, saturating
	nca_pkg::pow_t  acc_s3;    // a^(b mod 8), saturating
	nca_pkg::out_t  rsp_s4;

	nca_pkg::pow_t  x3_nxt;
	nca_pkg::pow_t  acc3_nxt;
	nca_pkg::pow_t  acc4;
	nca_pkg::out_t  rsp_nxt;

	// stage 2
	always_ff @(posedge clk) begin
		if (en.s2) begin
			side_s2 <= front.side;
			x_s2    <= {8'b0, front.sq} * {8'b0, front.sq};
			acc_s2  <= front.side.expo[1] ? ({8'b0, front.acc} * {4'b0, front.sq})
			                              : {8'b0, front.acc};
		end
	end

	// stage 3
	always_comb begin
		x3_nxt   = nca_pkg::pow_mul('{over: 1'b0, val: x_s2}, '{over: 1'b0, val: x_s2});
		acc3_nxt = '{over: 1'b0, val: 16'(acc_s2)};
		if (side_s2.expo[2]) begin
			acc3_nxt = nca_pkg::pow_mul(acc3_nxt, '{over: 1'b0, val: x_s2});
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			side_s3 <= side_s2;
			x_s3    <= x3_nxt;
			acc_s3  <= acc3_nxt;
		end
	end

	// stage 4: last multiply and result select into the output register
	always_comb begin
		acc4 = side_s3.expo[3] ? nca_pkg::pow_mul(acc_s3, x_s3) : acc_s3;
		rsp_nxt.result_value = side_s3.result_value;
		rsp_nxt.is_negative  = side_s3.is_negative;
		rsp_nxt.has_error    = side_s3.has_error;
		if (side_s3.is_pow) begin
			rsp_nxt.result_value = acc4.over ? nca_pkg::SAT_MAX : acc4.val;
			rsp_nxt.has_error    = acc4.over;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rsp_s4 <= rsp_nxt;
		end
	end

	assign rsp = rsp_s4;

endmodule

// ===== rtl/core/nibble_calculator_alu.sv =====
// nibble_calculator_alu: top level, pipeline valid bits and stall chain
// depends on nca_pkg, nca_front, nca_power
//
// usage
//   request channel: req carries operand_a, operand_b and command; a transfer
//   happens at a rising edge with req_valid high and req_stall low.
//   response channel: rsp carries result_value, is_negative and has_error;
//   a transfer happens with rsp_valid high and rsp_stall low.
//   exactly one response per request, in request order.
// pipeline and throughput
//   a request passes through stages 1 to 4 and rsp_valid is valid_s4: stage 1
//   finishes every command but power, stages 2 and 3 square and multiply
//   for power, stage 4 does the last multiply and the result select.
//   one request per cycle is taken while the response side keeps up.
// reset
//   arst_n clears all valid bits at once; the pipe comes out empty and
//   ready. payload registers are not reset.
// stall
//   each stage holds while it is full and the stage after it holds; a bubble
//   is filled even under stall. req_stall rises only when all four stages
//   are full and rsp_stall is high. the response held in the output
//   register does not change while stalled.
module nibble_calculator_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  nca_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output nca_pkg::out_t rsp
);

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	logic               en_s1;
	logic               en_s2;
	logic               en_s3;
	logic               en_s4;
	nca_pkg::front_t    front;
	nca_pkg::power_en_t pwr_en;

	// a stage loads when it is empty or its contents move on
	assign en_s4 = !valid_s4 || !rsp_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign req_stall = !en_s1;
	assign rsp_valid = valid_s4;

	assign pwr_en.s2 = en_s2;
	assign pwr_en.s3 = en_s3;
	assign pwr_en.s4 = en_s4;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= req_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// decode and all non-power commands
	nca_front u_front (
		.clk   (clk),
		.load  (en_s1),
		.req   (req),
		.front (front)
	);

	// power chain and output register
	nca_power u_power (
		.clk   (clk),
		.en    (pwr_en),
		.front (front),
		.rsp   (rsp)
	);

`ifndef SYNTHESIS
	// a taken request lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> valid_s1)
	else $error("accepted request did not enter stage 1");

	// back-pressure only when the whole pipe is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && rsp_stall))
	else $error("request stalled with room in the pipe");

	// only subtract sets the negative flag, and it never errors
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_negative) |-> !rsp.has_error)
	else $error("negative flag together with error");

	// an error result is either zero or the power saturation value
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.has_error) |->
			(rsp.result_value == 16'd0 || rsp.result_value == nca_pkg::SAT_MAX))
	else $error("error result with unexpected value");
`endif

endmodule
